// ===== rtl/fct_pkg.sv =====
// fct_pkg: shared types, widths and opcodes for the frustum cull test block
// no dependencies; imported by every rtl module of the block
`default_nettype none

package fct_pkg;

  // number of clipping planes held in configuration
  localparam int unsigned NumPlanes = 6;

  // arithmetic widths, all exact for the Q12.4 / Q1.14 formats
  localparam int unsigned CoordW = 16;  // signed Q12.4 coordinate
  localparam int unsigned ExtW   = 15;  // unsigned Q11.4 radius or half extent
  localparam int unsigned ProdW  = 32;  // signed normal times coordinate
  localparam int unsigned SpanW  = 31;  // |normal| times half extent
  localparam int unsigned BiasW  = 17;  // plane constant plus radius, Q13.4
  localparam int unsigned FracSh = 14;  // Q12.4 to 2^-18 units
  localparam int unsigned SumW   = 34;  // partial sums of three or four terms
  localparam int unsigned TotW   = 35;  // final margin
  localparam int unsigned RegW   = 64;  // one plane register

  // primitive opcodes
  typedef enum logic [1:0] {
    OP_POINT  = 2'd0,
    OP_SPHERE = 2'd1,
    OP_BOX    = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_e;

  // one plane register: bits 15:0 nx, 31:16 ny, 47:32 nz, 63:48 k
  typedef struct packed {
    logic signed [CoordW-1:0] k;
    logic signed [CoordW-1:0] nz;
    logic signed [CoordW-1:0] ny;
    logic signed [CoordW-1:0] nx;
  } plane_t;

  // pipeline load enables handed to each plane lane
  typedef struct packed {
    logic ld1;
    logic ld2;
  } lane_ctl_t;

  // magnitude of a Q1.14 normal component, the most negative code -2.0 gives 32768
  function automatic logic [CoordW-1:0] abs_norm(input logic signed [CoordW-1:0] n);
    logic [CoordW-1:0] u;
    u = n;
    return n[CoordW-1] ? (~u + CoordW'(1)) : u;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fct_apb_regs.sv =====
// fct_apb_regs: APB register file holding the clipping planes
// depends on fct_pkg for the plane type and register width
`default_nettype none

module fct_apb_regs #(
  parameter int unsigned NUM_PLANES = fct_pkg::NumPlanes,
  parameter int unsigned ADDR_W     = $clog2(NUM_PLANES * 8)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ADDR_W-1:0]              paddr,
  input  wire logic [fct_pkg::RegW-1:0]       pwdata,
  output logic      [fct_pkg::RegW-1:0]       prdata,
  output logic                                pready,
  output fct_pkg::plane_t [NUM_PLANES-1:0]    planes_o
);
  import fct_pkg::*;

  localparam int unsigned IdxW = ADDR_W - 3;

  logic [RegW-1:0] planes_q [NUM_PLANES];
  logic [IdxW-1:0] idx;
  logic            wr_en;

  assign idx    = paddr[ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // plane registers, out of range writes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        planes_q[i] <= '0;
      end
    end else if (wr_en) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        if (idx == IdxW'(i)) begin
          planes_q[i] <= pwdata;
        end
      end
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    for (int i = 0; i < NUM_PLANES; i++) begin
      if (idx == IdxW'(i)) begin
        prdata = planes_q[i];
      end
    end
  end

  // planes out to the lanes
  always_comb begin
    for (int i = 0; i < NUM_PLANES; i++) begin
      planes_o[i] = plane_t'(planes_q[i]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fct_plane_lane.sv =====
// fct_plane_lane: margin of one primitive against one plane, two register stages
// depends on fct_pkg for widths, opcodes and the plane type
`default_nettype none

module fct_plane_lane (
  input  wire logic                                clk_i,
  input  wire fct_pkg::lane_ctl_t                  ctl_i,
  input  wire fct_pkg::plane_t                     plane_i,
  input  wire fct_pkg::opcode_e                    opcode_i,
  input  wire logic signed [fct_pkg::CoordW-1:0]   center_x_i,
  input  wire logic signed [fct_pkg::CoordW-1:0]   center_y_i,
  input  wire logic signed [fct_pkg::CoordW-1:0]   center_z_i,
  input  wire logic        [fct_pkg::ExtW-1:0]     sphere_radius_i,
  input  wire logic        [fct_pkg::ExtW-1:0]     half_x_i,
  input  wire logic        [fct_pkg::ExtW-1:0]     half_y_i,
  input  wire logic        [fct_pkg::ExtW-1:0]     half_z_i,
  output logic                                     pass_o
);
  import fct_pkg::*;

  // stage 1: products
  logic signed [ProdW-1:0] px_d, py_d, pz_d, px_q, py_q, pz_q;
  logic        [SpanW-1:0] ex_d, ey_d, ez_d, ex_q, ey_q, ez_q;
  logic        [BiasW-1:0] bias_d, bias_q;
  logic                    is_box, is_sph;

  assign is_box = (opcode_i == OP_BOX);
  assign is_sph = (opcode_i == OP_SPHERE);

  // dot product terms and the box reach |n|.h, zero unless box
  always_comb begin
    px_d   = ProdW'(plane_i.nx) * ProdW'(center_x_i);
    py_d   = ProdW'(plane_i.ny) * ProdW'(center_y_i);
    pz_d   = ProdW'(plane_i.nz) * ProdW'(center_z_i);
    ex_d   = is_box ? SpanW'(abs_norm(plane_i.nx)) * SpanW'(half_x_i) : '0;
    ey_d   = is_box ? SpanW'(abs_norm(plane_i.ny)) * SpanW'(half_y_i) : '0;
    ez_d   = is_box ? SpanW'(abs_norm(plane_i.nz)) * SpanW'(half_z_i) : '0;
    bias_d = BiasW'(plane_i.k) + (is_sph ? BiasW'(sphere_radius_i) : '0);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld1) begin
      px_q   <= px_d;
      py_q   <= py_d;
      pz_q   <= pz_d;
      ex_q   <= ex_d;
      ey_q   <= ey_d;
      ez_q   <= ez_d;
      bias_q <= bias_d;
    end
  end

  // stage 2: partial sums
  logic signed [SumW-1:0] sa_d, sb_d, sa_q, sb_q;

  always_comb begin
    sa_d = SumW'(px_q) + SumW'(py_q) + SumW'(pz_q);
    sb_d = SumW'(ex_q) + SumW'(ey_q) + SumW'(ez_q)
         + SumW'($signed({bias_q, FracSh'(0)}));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld2) begin
      sa_q <= sa_d;
      sb_q <= sb_d;
    end
  end

  // final margin, the plane keeps the primitive when it is positive
  logic signed [TotW-1:0] margin;

  assign margin = TotW'(sa_q) + TotW'(sb_q);
  assign pass_o = (margin > 0);

endmodule

`default_nettype wire

// ===== rtl/frustum_cull_test.sv =====
// frustum_cull_test: tests a point, sphere or box against NUM_PLANES clipping planes, six by default
// throughput: 1 item per cycle while out_stall_i does not hold the pipeline
// stages: products, partial sums, final add with compare into the output register
// reset: pipeline emptied, all planes cleared to zero, so points and boxes cull until written
// depends on fct_pkg, fct_apb_regs and fct_plane_lane
`default_nettype none

module frustum_cull_test #(
  parameter int unsigned NUM_PLANES = fct_pkg::NumPlanes,
  parameter int unsigned ADDR_W     = $clog2(NUM_PLANES * 8)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // apb configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ADDR_W-1:0]                   paddr,
  input  wire logic [fct_pkg::RegW-1:0]            pwdata,
  output logic      [fct_pkg::RegW-1:0]            prdata,
  output logic                                     pready,
  // input items
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          opcode_i,
  input  wire logic signed [fct_pkg::CoordW-1:0]   center_x_i,
  input  wire logic signed [fct_pkg::CoordW-1:0]   center_y_i,
  input  wire logic signed [fct_pkg::CoordW-1:0]   center_z_i,
  input  wire logic        [fct_pkg::ExtW-1:0]     sphere_radius_i,
  input  wire logic        [fct_pkg::ExtW-1:0]     half_x_i,
  input  wire logic        [fct_pkg::ExtW-1:0]     half_y_i,
  input  wire logic        [fct_pkg::ExtW-1:0]     half_z_i,
  // result items
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     visible_o
);
  import fct_pkg::*;

  plane_t [NUM_PLANES-1:0] planes;

  fct_apb_regs #(
    .NUM_PLANES (NUM_PLANES),
    .ADDR_W     (ADDR_W)
  ) u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .planes_o (planes)
  );

  // pipeline flow control, each stage moves when the next has room
  logic      v1_q, v2_q, v3_q;
  logic      rdy1, rdy2, rdy3;
  lane_ctl_t ctl;

  assign rdy3       = !v3_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;
  assign ctl.ld1    = rdy1 && in_valid_i;
  assign ctl.ld2    = rdy2 && v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // reserved opcode travels beside the lanes
  opcode_e op;
  logic    rsvd1_q, rsvd2_q;

  assign op = opcode_e'(opcode_i);

  always_ff @(posedge clk_i) begin
    if (ctl.ld1) begin
      rsvd1_q <= (op == OP_RSVD);
    end
    if (ctl.ld2) begin
      rsvd2_q <= rsvd1_q;
    end
  end

  // one lane per plane
  logic [NUM_PLANES-1:0] pass;

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    fct_plane_lane u_lane (
      .clk_i           (clk_i),
      .ctl_i           (ctl),
      .plane_i         (planes[p]),
      .opcode_i        (op),
      .center_x_i      (center_x_i),
      .center_y_i      (center_y_i),
      .center_z_i      (center_z_i),
      .sphere_radius_i (sphere_radius_i),
      .half_x_i        (half_x_i),
      .half_y_i        (half_y_i),
      .half_z_i        (half_z_i),
      .pass_o          (pass[p])
    );
  end

  // output register, visible only when the opcode is not reserved and every plane keeps the item
  logic visible_d, visible_q;

  assign visible_d = !rsvd2_q && (&pass);

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      visible_q <= visible_d;
    end
  end

  assign out_valid_o = v3_q;
  assign visible_o   = visible_q;

endmodule

`default_nettype wire
